@@ sv/hex_escape_codec_defines.svh @@
// assertion macros shared by the codec
`ifndef HEX_ESCAPE_CODEC_DEFINES_SVH
`define HEX_ESCAPE_CODEC_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hec_pkg.sv @@
package hec_pkg;

  localparam logic [7:0] BACKTICK    = 8'h60;
  localparam int         QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_run;
  } out_item_t;

  // up to three output bytes, bytes[0] leaves first; cnt is 1..3
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } job_t;

  typedef enum logic [2:0] {
    HOLD_NONE  = 3'b001,
    HOLD_TICK  = 3'b010,
    HOLD_DIGIT = 3'b100
  } hold_t;

  // passes through unchanged in encode mode
  function automatic logic is_plain(input logic [7:0] c);
    return ((c >= 8'h20) && (c <= 8'h7e) && (c != BACKTICK)) ||
           (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
  endfunction

  // lowercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + ext) : (8'h57 + ext);
  endfunction

  // {valid, nibble} of a hex digit of either case
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] res;
    res = 5'b0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      res = {1'b1, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

@@ sv/hex_escape_codec.sv @@
// backtick hex escape codec: in encode mode each byte leaves as itself when it
// is printable ascii (not backtick), newline, return or tab, and otherwise as a
// backtick plus two lowercase hex digits; in decode mode a backtick and two hex
// digits of either case collapse into one byte, a broken escape leaves raw, and
// a flush request releases whatever is held. the front classifies each request
// and pushes a job of up to three bytes into a small queue; the back end
// sends one byte per cycle from a registered output stage while the receiver
// is ready, holding when it is not. writing cfg_decode_mode drops any held
// escape; write it only while the codec is idle.
`include "hex_escape_codec_defines.svh"

module hex_escape_codec #(
  parameter int QUEUE_DEPTH = hec_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hec_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hec_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_decode_mode
);

  // front to queue
  logic          q_push;
  hec_pkg::job_t q_job;
  logic          q_full;
  // queue to back end
  logic          q_pop;
  logic          q_empty;
  hec_pkg::job_t q_head;
  // no partial escape held
  logic          hold_idle;

  // classify and track the escape hold
  hec_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decode_mode (cfg_decode_mode),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_job),
    .hold_idle       (hold_idle)
  );

  // decouples classification from byte output
  hec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // serialize jobs, one byte per cycle while the receiver is ready
  hec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `HEC_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "queue popped while empty")
  `HEC_ASSERT_IMP(a_no_push_full, q_push, !q_full, "queue pushed while full")
  `HEC_ASSERT_NXT(a_cfg_clears_hold, cfg_valid && cfg_ready, hold_idle, "hold kept over mode write")
  `HEC_ASSERT_NXT(a_flush_clears_hold, in_valid && in_ready && in_data.flush, hold_idle, "hold kept over flush")

endmodule

@@ sv/hec_front.sv @@
module hec_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hec_pkg::in_item_t in_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_decode_mode,
  input  logic             q_full,
  output logic             q_push,
  output hec_pkg::job_t    q_job,
  output logic             hold_idle
);

  logic           mode_r;
  hec_pkg::hold_t phase_r, phase_nxt;
  logic [7:0]     held_r, held_nxt;
  logic [7:0]     c;
  logic [4:0]     hv;
  logic [4:0]     hh;
  logic           accept;
  hec_pkg::job_t  job;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && (job.cnt != 2'd0);
  assign q_job     = job;
  assign hold_idle = (phase_r == hec_pkg::HOLD_NONE);

  always_comb begin
    c         = in_data.byte_in;
    hv        = hec_pkg::hex_value(c);
    hh        = hec_pkg::hex_value(held_r);
    job       = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (in_data.flush) begin
      unique case (phase_r)
        hec_pkg::HOLD_TICK: begin
          job.bytes[0] = hec_pkg::BACKTICK;
          job.cnt      = 2'd1;
        end
        hec_pkg::HOLD_DIGIT: begin
          job.bytes[0] = hec_pkg::BACKTICK;
          job.bytes[1] = held_r;
          job.cnt      = 2'd2;
        end
        default: ;
      endcase
      phase_nxt = hec_pkg::HOLD_NONE;
      held_nxt  = 8'h00;
    end else if (!mode_r) begin
      if (hec_pkg::is_plain(c)) begin
        job.bytes[0] = c;
        job.cnt      = 2'd1;
      end else begin
        job.bytes[0] = hec_pkg::BACKTICK;
        job.bytes[1] = hec_pkg::hex_char(c[7:4]);
        job.bytes[2] = hec_pkg::hex_char(c[3:0]);
        job.cnt      = 2'd3;
      end
    end else begin
      unique case (phase_r)
        hec_pkg::HOLD_TICK: begin
          if (hv[4]) begin
            held_nxt  = c;
            phase_nxt = hec_pkg::HOLD_DIGIT;
          end else begin
            job.bytes[0] = hec_pkg::BACKTICK;
            if (c == hec_pkg::BACKTICK) begin
              job.cnt   = 2'd1;
              phase_nxt = hec_pkg::HOLD_TICK;
            end else begin
              job.bytes[1] = c;
              job.cnt      = 2'd2;
              phase_nxt    = hec_pkg::HOLD_NONE;
            end
          end
        end
        hec_pkg::HOLD_DIGIT: begin
          held_nxt = 8'h00;
          if (hv[4]) begin
            job.bytes[0] = {hh[3:0], hv[3:0]};
            job.cnt      = 2'd1;
            phase_nxt    = hec_pkg::HOLD_NONE;
          end else begin
            job.bytes[0] = hec_pkg::BACKTICK;
            job.bytes[1] = held_r;
            if (c == hec_pkg::BACKTICK) begin
              job.cnt   = 2'd2;
              phase_nxt = hec_pkg::HOLD_TICK;
            end else begin
              job.bytes[2] = c;
              job.cnt      = 2'd3;
              phase_nxt    = hec_pkg::HOLD_NONE;
            end
          end
        end
        default: begin
          if (c == hec_pkg::BACKTICK) begin
            phase_nxt = hec_pkg::HOLD_TICK;
          end else begin
            job.bytes[0] = c;
            job.cnt      = 2'd1;
            phase_nxt    = hec_pkg::HOLD_NONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= hec_pkg::HOLD_NONE;
      held_r  <= 8'h00;
    end else if (cfg_valid) begin
      // any mode write drops a partial escape
      mode_r  <= cfg_decode_mode;
      phase_r <= hec_pkg::HOLD_NONE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

@@ sv/hec_queue.sv @@
module hec_queue #(
  parameter int DEPTH = hec_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hec_pkg::job_t push_job,
  input  logic          pop,
  output hec_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hec_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/hec_back.sv @@
module hec_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hec_pkg::job_t     head_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output hec_pkg::out_item_t out_data
);

  logic               cur_valid_r;
  hec_pkg::job_t      cur_job_r;
  logic [1:0]         idx_r;
  logic               out_valid_r;
  hec_pkg::out_item_t out_data_r;
  logic               slot_free;
  logic               emit;
  logic               last;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = cur_valid_r && slot_free;
  assign last      = (idx_r == (cur_job_r.cnt - 2'd1));
  assign q_pop     = !q_empty && (!cur_valid_r || (emit && last));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.byte_out    <= cur_job_r.bytes[idx_r];
      out_data_r.last_of_run <= last;
    end
    if (q_pop) begin
      cur_job_r <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (emit && last) begin
        cur_valid_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

@@ verif/hex_escape_codec_tb.sv @@
module hex_escape_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hec_pkg::*;

  // cycles the receiver holds off when asked for a long stall
  localparam int LONG_STALL    = 60;
  // quiet cycles before a mode write, covers a request still in the front
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 46;

  // tracks codec state and the byte stream each request should produce
  class escape_scoreboard;
    logic       decode_on;
    hold_t      hold;
    logic [7:0] digit_held;
    out_item_t  awaited[$];
    int mismatches, checked, requests, flushes;
    int escapes_made, escapes_decoded, raw_releases;

    function new();
      set_mode(1'b0);
      mismatches      = 0;
      checked         = 0;
      requests        = 0;
      flushes         = 0;
      escapes_made    = 0;
      escapes_decoded = 0;
      raw_releases    = 0;
    endfunction

    // a mode write always drops a partial escape
    function void set_mode(logic m);
      decode_on  = m;
      hold       = HOLD_NONE;
      digit_held = 8'h00;
    endfunction

    // nibble of a hex digit of either case, -1 otherwise
    static function int digit_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    static function logic [7:0] nibble_char(logic [3:0] n);
      if (n < 4'd10) return {4'h3, n};
      return 8'h61 + 8'(n - 4'd10);
    endfunction

    static function bit passes_through(logic [7:0] c);
      return (c >= 8'h20 && c <= 8'h7e && c != BACKTICK) ||
             c == 8'h0a || c == 8'h0d || c == 8'h09;
    endfunction

    function bit empty();
      return awaited.size() == 0;
    endfunction

    // works out the bytes one accepted request causes
    function void note_input(in_item_t it);
      logic [7:0] run[$];
      logic [7:0] c;
      int         v;
      bit         fresh;
      c = it.byte_in;
      requests++;
      if (it.flush) begin
        flushes++;
        if (hold != HOLD_NONE) run.push_back(BACKTICK);
        if (hold == HOLD_DIGIT) run.push_back(digit_held);
        hold       = HOLD_NONE;
        digit_held = 8'h00;
      end else if (!decode_on) begin
        if (passes_through(c)) begin
          run.push_back(c);
        end else begin
          run.push_back(BACKTICK);
          run.push_back(nibble_char(c[7:4]));
          run.push_back(nibble_char(c[3:0]));
          escapes_made++;
        end
      end else begin
        v     = digit_nibble(c);
        fresh = 1'b1;
        case (hold)
          HOLD_TICK: begin
            if (v >= 0) begin
              digit_held = c;
              hold       = HOLD_DIGIT;
              fresh      = 1'b0;
            end else begin
              run.push_back(BACKTICK);
              hold = HOLD_NONE;
              raw_releases++;
            end
          end
          HOLD_DIGIT: begin
            if (v >= 0) begin
              run.push_back(8'(digit_nibble(digit_held) * 16 + v));
              fresh = 1'b0;
              escapes_decoded++;
            end else begin
              run.push_back(BACKTICK);
              run.push_back(digit_held);
              raw_releases++;
            end
            hold       = HOLD_NONE;
            digit_held = 8'h00;
          end
          default: hold = HOLD_NONE;
        endcase
        if (fresh) begin
          if (c == BACKTICK) hold = HOLD_TICK;
          else run.push_back(c);
        end
      end
      foreach (run[i]) awaited.push_back(out_item_t'{byte_out: run[i],
                                                     last_of_run: (i == run.size() - 1)});
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: nothing expected, got byte %02h last %0b",
                   checked, got.byte_out, got.last_of_run);
        return;
      end
      want = awaited.pop_front();
      if (got.byte_out !== want.byte_out || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                   checked, want.byte_out, want.last_of_run, got.byte_out, got.last_of_run);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n           = 1'b0;
  logic      in_valid        = 1'b0;
  in_item_t  in_data         = '0;
  logic      out_ready       = 1'b0;
  logic      cfg_valid       = 1'b0;
  logic      cfg_decode_mode = 1'b0;
  logic      in_ready, out_valid, cfg_ready;
  out_item_t out_data;

  // steady: neither side idles; stall_asks: sender asks the receiver for a long hold-off
  bit steady     = 1'b0;
  int stall_asks = 0;

  escape_scoreboard sb;

  hex_escape_codec dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decode_mode (cfg_decode_mode)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the codec hangs
  initial begin
    #400_000;
    $display("FAILED: results differ");
    $finish;
  end

  // monitor: handshakes are sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver: random backpressure, or a long counted hold-off on request
  initial begin
    int stall_done;
    stall_done = 0;
    forever begin
      @(posedge clk);
      if (stall_asks != stall_done) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_done++;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // one request; valid is only lowered when an idle gap is taken
  task automatic push_request(input logic [7:0] b, input logic fl);
    if (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 32);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{byte_in: b, flush: fl};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every expected byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!sb.empty()) @(posedge clk);
  endtask

  // mode write on an idle codec; a held escape may still sit in the front
  task automatic write_mode(input logic m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_decode_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    logic [3:0] nib;
    nib = 4'($urandom_range(0, 15));
    if (nib < 4'd10) return {4'h3, nib};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (escape_scoreboard::digit_nibble(c) >= 0);
    return c;
  endfunction

  // encode traffic; dense leans on bytes that expand to three
  task automatic run_encode_phase(input int count, input bit dense);
    logic [7:0] b;
    repeat (count) begin
      if (dense && $urandom_range(0, 1)) b = 8'($urandom_range(128, 255));
      else b = 8'($urandom_range(0, 255));
      push_request(b, $urandom_range(0, 99) < 6);
    end
  endtask

  // decode traffic: mostly well-formed escapes, mixed with broken ones and noise
  task automatic run_decode_phase(input int count);
    int sent, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_request(BACKTICK, 1'b0);
        push_request(rand_hex_digit(), 1'b0);
        push_request(rand_hex_digit(), 1'b0);
        sent += 3;
      end else if (pick < 63) begin
        // non-hex right after the backtick
        push_request(BACKTICK, 1'b0);
        push_request(rand_non_hex(), 1'b0);
        sent += 2;
      end else if (pick < 71) begin
        // non-hex after the first digit
        push_request(BACKTICK, 1'b0);
        push_request(rand_hex_digit(), 1'b0);
        push_request(rand_non_hex(), 1'b0);
        sent += 3;
      end else if (pick < 78) begin
        // partial escape cut off by a flush
        push_request(BACKTICK, 1'b0);
        if ($urandom_range(0, 1)) begin
          push_request(rand_hex_digit(), 1'b0);
          sent++;
        end
        push_request(8'($urandom_range(0, 255)), 1'b1);
        sent += 2;
      end else begin
        push_request(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode out of reset: range ends, backtick, controls kept and escaped
    push_request(8'h00, 1'b0);
    push_request(8'hff, 1'b0);
    push_request(BACKTICK, 1'b0);
    push_request(8'h7e, 1'b0);
    push_request(8'h7f, 1'b0);
    push_request(8'h1f, 1'b0);
    push_request(8'h09, 1'b0);
    // flush with nothing held gives no bytes
    push_request(8'ha5, 1'b1);

    write_mode(1'b1);
    // escapes in both digit cases
    push_request(BACKTICK, 1'b0);
    push_request("4", 1'b0);
    push_request("1", 1'b0);
    push_request(BACKTICK, 1'b0);
    push_request("A", 1'b0);
    push_request("f", 1'b0);
    // non-hex after the backtick
    push_request(BACKTICK, 1'b0);
    push_request("g", 1'b0);
    // backtick after a held digit, then non-hex after a digit
    push_request(BACKTICK, 1'b0);
    push_request("3", 1'b0);
    push_request(BACKTICK, 1'b0);
    push_request("9", 1'b0);
    push_request("q", 1'b0);
    // flush with a digit held, then with only the backtick held
    push_request(BACKTICK, 1'b0);
    push_request("c", 1'b0);
    push_request(8'h00, 1'b1);
    push_request(BACKTICK, 1'b0);
    push_request(8'hff, 1'b1);
    // a mode write drops the held backtick
    push_request(BACKTICK, 1'b0);
    write_mode(1'b1);
    push_request("4", 1'b0);

    // random phases with both modes
    write_mode(1'b0);
    run_encode_phase(PHASE_ITEMS, 1'b0);

    write_mode(1'b1);
    run_decode_phase(PHASE_ITEMS / 2);
    // sender pauses until the output side is empty
    wait_drained();
    run_decode_phase(PHASE_ITEMS / 2);

    // no idling on either side, then a long receiver hold-off so the codec fills up
    write_mode(1'b0);
    steady = 1'b1;
    run_encode_phase(PHASE_ITEMS / 2, 1'b1);
    stall_asks++;
    run_encode_phase(PHASE_ITEMS / 2, 1'b1);
    steady = 1'b0;

    write_mode(1'b1);
    run_decode_phase(PHASE_ITEMS);
    write_mode(1'b0);
    run_encode_phase(PHASE_ITEMS / 2, 1'b0);

    // final drain, then watch for stray bytes
    wait_drained();
    repeat (3 * SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d requests (%0d flushes) in both modes, %0d bytes checked",
             sb.requests, sb.flushes, sb.checked);
    $display("run: %0d bytes escaped, %0d escapes decoded, %0d broken escapes passed raw",
             sb.escapes_made, sb.escapes_decoded, sb.raw_releases);
    if (sb.mismatches == 0 && sb.empty()) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", sb.mismatches, sb.awaited.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
